[hw/rtl/scf_pkg.sv]
package scf_pkg;

  // Frame buffer depth, in bytes
  localparam int unsigned BufferDepth = 64;

  // Width of a frame length and of the fixed-length register
  localparam int unsigned LenW = 7;

  // Configuration reset values
  localparam logic [15:0]     GapTimeoutRst = 16'd50;
  localparam logic [7:0]      LineLeadARst  = 8'h40;  // '@'
  localparam logic [7:0]      LineLeadBRst  = 8'h23;  // '#'
  localparam logic [7:0]      FixedLeadRst  = 8'h33;  // '3'
  localparam logic [LenW-1:0] FixedLenRst   = 7'd8;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic KindLine  = 1'b0;
  localparam logic KindFixed = 1'b1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegGapTimeout = 3'd0,
    RegLineLeadA  = 3'd1,
    RegLineLeadB  = 3'd2,
    RegFixedLead  = 3'd3,
    RegFixedLen   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]     gap_timeout;
    logic [7:0]      lead_a;
    logic [7:0]      lead_b;
    logic [7:0]      fixed_lead;
    logic [LenW-1:0] fixed_len;
  } cfg_t;

  // Completed frame handed from front to back
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
    logic            kind;
  } desc_t;

  // Back end frees a bank once its last byte is read out
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

[hw/rtl/scf_ram.sv]
module scf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/scf_fifo.sv]
// Two-entry descriptor queue between front and back
module scf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scf_pkg::desc_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output scf_pkg::desc_t data_o,
  output logic           empty_o
);

  scf_pkg::desc_t mem_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           wp_q, rp_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

[hw/rtl/scf_front.sv]
// Accepts bytes, tracks the gap and fill level, stores into the current bank,
// and detects frame completion.
module scf_front #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::BufferDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scf_pkg::cfg_t                     cfg_i,
  input  logic                              push_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic [31:0]                       tick_ms_i,
  output logic                              full_o,
  input  scf_pkg::release_t                 rel_i,
  output logic                              ram_we_o,
  output logic [$clog2(BUFFER_DEPTH):0]     ram_waddr_o,
  output logic [7:0]                        ram_wdata_o,
  output logic                              desc_push_o,
  output scf_pkg::desc_t                    desc_o,
  input  logic                              desc_full_i
);

  localparam int unsigned IdxW  = $clog2(BUFFER_DEPTH);
  localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_GAP,
    F_STORE,
    F_HAND
  } fstate_e;

  fstate_e           state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [31:0]       prev_tick_q, prev_tick_d;
  logic              over_q, over_d;
  logic [7:0]        first_q, first_d;
  logic              kind_q, kind_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;

  logic [7:0]        byte_q;
  logic [31:0]       tick_q;

  logic [IdxW-1:0]   idx;
  logic [FillW-1:0]  fill_new;
  logic [7:0]        first_new;
  logic              is_line, is_term, done;
  logic              accept;
  logic [31:0]       gap;

  assign full_o = (state_q != F_IDLE) || busy_q[bank_q];
  assign accept = push_i && !full_o;
  assign gap    = tick_q - prev_tick_q;

  // Restart the buffer on a timeout or when it is already full
  assign idx       = (over_q || fill_q == FillW'(BUFFER_DEPTH)) ? '0 : fill_q[IdxW-1:0];
  assign fill_new  = FillW'(idx) + FillW'(1);
  assign first_new = (idx == '0) ? byte_q : first_q;
  assign is_line   = (first_new == cfg_i.lead_a) || (first_new == cfg_i.lead_b);
  assign is_term   = (byte_q == scf_pkg::CharCr) || (byte_q == scf_pkg::CharLf);
  // Line rule takes priority when leads overlap
  assign done      = is_line ? is_term
                             : ((first_new == cfg_i.fixed_lead) &&
                                (scf_pkg::LenW'(fill_new) == cfg_i.fixed_len));

  assign ram_we_o    = (state_q == F_STORE);
  assign ram_waddr_o = {bank_q, idx};
  assign ram_wdata_o = byte_q;

  assign desc_push_o = (state_q == F_HAND) && !desc_full_i;
  assign desc_o      = '{bank: bank_q, len: scf_pkg::LenW'(fill_q), kind: kind_q};

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    prev_tick_d = prev_tick_q;
    over_d      = over_q;
    first_d     = first_q;
    kind_d      = kind_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_GAP;
        end
      end
      F_GAP: begin
        over_d      = gap > {16'd0, cfg_i.gap_timeout};
        prev_tick_d = tick_q;
        state_d     = F_STORE;
      end
      F_STORE: begin
        fill_d  = fill_new;
        first_d = first_new;
        kind_d  = is_line ? scf_pkg::KindLine : scf_pkg::KindFixed;
        state_d = done ? F_HAND : F_IDLE;
      end
      F_HAND: begin
        if (!desc_full_i) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
          fill_d         = '0;
          state_d        = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      fill_q      <= '0;
      prev_tick_q <= '0;
      over_q      <= 1'b0;
      first_q     <= '0;
      kind_q      <= scf_pkg::KindLine;
      bank_q      <= 1'b0;
      busy_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      prev_tick_q <= prev_tick_d;
      over_q      <= over_d;
      first_q     <= first_d;
      kind_q      <= kind_d;
      bank_q      <= bank_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
      tick_q <= tick_ms_i;
    end
  end

endmodule

[hw/rtl/scf_back.sv]
// Reads completed frames out of the buffer, one byte per read, into the
// output register.
module scf_back #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::BufferDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_empty_i,
  input  scf_pkg::desc_t                desc_i,
  output logic                          desc_pop_o,
  output logic                          ram_re_o,
  output logic [$clog2(BUFFER_DEPTH):0] ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i,
  output scf_pkg::release_t             rel_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    frame_byte_o,
  output logic                          frame_last_o,
  output logic                          frame_kind_o
);

  localparam int unsigned IdxW  = $clog2(BUFFER_DEPTH);
  localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DATA
  } bstate_e;

  bstate_e          state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  scf_pkg::desc_t   cur_q, cur_d;
  logic             out_v_q, out_v_d;
  logic             out_free, is_last;

  logic [7:0]       byte_q;
  logic             last_q, kind_q;

  assign empty        = !out_v_q;
  assign out_free     = !out_v_q || pop;
  assign is_last      = scf_pkg::LenW'(FillW'(idx_q) + FillW'(1)) == cur_q.len;

  assign desc_pop_o   = (state_q == B_IDLE) && !desc_empty_i;
  assign ram_re_o     = (state_q == B_RUN) && out_free;
  assign ram_raddr_o  = {cur_q.bank, idx_q};
  assign rel_o        = '{valid: (state_q == B_DATA) && is_last, bank: cur_q.bank};

  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;
  assign frame_kind_o = kind_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    out_v_d = out_v_q;
    if (pop) begin
      out_v_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (!desc_empty_i) begin
          cur_d   = desc_i;
          idx_d   = '0;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (out_free) begin
          state_d = B_DATA;
        end
      end
      B_DATA: begin
        // Output register is known free here
        out_v_d = 1'b1;
        if (is_last) begin
          state_d = B_IDLE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = B_RUN;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      cur_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_DATA) begin
      byte_q <= ram_rdata_i;
      last_q <= is_last;
      kind_q <= cur_q.kind;
    end
  end

endmodule

[hw/rtl/serial_command_framer.sv]
// Serial command framer.
// Input channel: present rx_byte_i and tick_ms_i with push; a transaction
// completes on a clock edge with push high and full low. Each byte then passes
// the front end steps capture, gap check and store, with full high until it
// is stored; a byte that completes a frame also waits in a hand-off step
// until the descriptor queue takes the frame. Output channel: while empty is
// low, frame_byte_o/frame_last_o/frame_kind_o show the oldest frame byte; pop
// takes it. The back end reads each byte from the buffer, then loads it into
// the output register, and starts the next read only once the register is free.
// The buffer has two banks: the front end fills one while the back end reads
// the other. If the receiver stalls, the waiting frame stays in its bank and
// the front end keeps collecting into the other; beyond the per-byte busy
// cycles, full stays high once a second frame completes while both banks
// are still held.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; write only while idle. Unknown indexes are ignored.
// Reset: all control state clears at once (empty buffer, previous tick of
// zero, configuration defaults); no clearing pass, the buffer needs none.
module serial_command_framer #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::BufferDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte_i,
  input  logic [31:0]                  tick_ms_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   frame_byte_o,
  output logic                         frame_last_o,
  output logic                         frame_kind_o
);

  // Two banks of 2**IdxW bytes, bank select on the top address bit
  localparam int unsigned IdxW    = $clog2(BUFFER_DEPTH);
  localparam int unsigned AddrW   = IdxW + 1;
  localparam int unsigned RamDepth = 1 << AddrW;

  scf_pkg::cfg_t     cfg_q;
  scf_pkg::desc_t    desc_in, desc_out;
  scf_pkg::release_t rel;
  logic              desc_push, desc_full, desc_pop, desc_empty;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_timeout <= scf_pkg::GapTimeoutRst;
      cfg_q.lead_a      <= scf_pkg::LineLeadARst;
      cfg_q.lead_b      <= scf_pkg::LineLeadBRst;
      cfg_q.fixed_lead  <= scf_pkg::FixedLeadRst;
      cfg_q.fixed_len   <= scf_pkg::FixedLenRst;
    end else if (cfg_we_i) begin
      case (scf_pkg::cfg_reg_e'(cfg_idx_i))
        scf_pkg::RegGapTimeout: cfg_q.gap_timeout <= cfg_wdata_i;
        scf_pkg::RegLineLeadA:  cfg_q.lead_a      <= cfg_wdata_i[7:0];
        scf_pkg::RegLineLeadB:  cfg_q.lead_b      <= cfg_wdata_i[7:0];
        scf_pkg::RegFixedLead:  cfg_q.fixed_lead  <= cfg_wdata_i[7:0];
        scf_pkg::RegFixedLen:   cfg_q.fixed_len   <= cfg_wdata_i[scf_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  scf_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .push_i      (push),
    .rx_byte_i,
    .tick_ms_i,
    .full_o      (full),
    .rel_i       (rel),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .desc_push_o (desc_push),
    .desc_o      (desc_in),
    .desc_full_i (desc_full)
  );

  scf_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (desc_push),
    .data_i  (desc_in),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .data_o  (desc_out),
    .empty_o (desc_empty)
  );

  scf_ram #(.WIDTH(8), .DEPTH(RamDepth)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scf_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk_i,
    .rst_ni,
    .desc_empty_i (desc_empty),
    .desc_i       (desc_out),
    .desc_pop_o   (desc_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rel_o        (rel),
    .empty,
    .pop,
    .frame_byte_o,
    .frame_last_o,
    .frame_kind_o
  );

endmodule

[hw/rtl/scf_checker.sv]
module scf_checker #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::BufferDepth
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o,
  input logic       frame_kind_o
);

  localparam int unsigned PosW = $clog2(BUFFER_DEPTH + 1);

  logic            mid_q;
  logic            kind_q;
  logic [PosW-1:0] pos_q;
  logic            take;

  assign take = pop && !empty;

  // Track position and kind within the frame being read out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= 1'b0;
      kind_q <= 1'b0;
      pos_q  <= '0;
    end else if (take) begin
      mid_q  <= !frame_last_o;
      kind_q <= frame_kind_o;
      pos_q  <= frame_last_o ? '0 : pos_q + PosW'(1);
    end
  end

  // Waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  // Front end is busy in the cycle after taking a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("byte accepted on consecutive cycles");

  // Kind never changes inside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && mid_q |-> frame_kind_o == kind_q)
    else $error("frame kind changed inside a frame");

  // No frame is longer than the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> pos_q < PosW'(BUFFER_DEPTH))
    else $error("frame longer than buffer");

endmodule

bind serial_command_framer scf_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_scf_checker (.*);
